// File: rtl/pir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pir_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [63:0] STEP_SMALL = 64'h0000_0000_0000_1000;
	localparam logic [63:0] STEP_LARGE = 64'h0000_0000_0020_0000;

	// register indexes (paddr[5:3])
	localparam logic [2:0] REG_HOLD_MODE  = 3'd0;
	localparam logic [2:0] REG_PF_ARM     = 3'd1;
	localparam logic [2:0] REG_PF_FROM    = 3'd2;
	localparam logic [2:0] REG_PF_TO      = 3'd3;
	localparam logic [2:0] REG_PF_ERRCODE = 3'd4;

	localparam logic REQ_EXT_INTR = 1'b0;
	localparam logic REQ_WINDOW   = 1'b1;

	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_PF   = 1'b1;

	localparam logic [1:0] WIN_NONE    = 2'd0;
	localparam logic [1:0] WIN_ENABLE  = 2'd1;
	localparam logic [1:0] WIN_DISABLE = 2'd2;

	localparam logic [1:0] ST_HANDLED = 2'd0;
	localparam logic [1:0] ST_QUEUED  = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_BADTYPE = 2'd3;

	localparam logic [2:0] INTR_TYPE_EXT = 3'd0;

	typedef struct packed {
		logic        req_type;
		logic [31:0] intr_info;
		logic        guest_if;
		logic        block_mov_ss;
		logic        large_page;
	} pir_in_t;

	typedef struct packed {
		logic        inject_valid;
		logic        inject_kind;
		logic [31:0] inject_word;
		logic [63:0] fault_address;
		logic [31:0] fault_code;
		logic [1:0]  window_ctl;
		logic [1:0]  status;
	} pir_out_t;

	typedef struct packed {
		logic        hold_mode;
		logic        pf_arm;
		logic [63:0] pf_range_from;
		logic [63:0] pf_range_to;
		logic [31:0] pf_error_code;
	} pir_cfg_t;

	// side effects of register writes on datapath state
	typedef struct packed {
		logic        load_waiting;
		logic        waiting_val;
		logic        load_cursor;
		logic [63:0] cursor_val;
	} pir_cfgwr_t;

	typedef struct packed {
		logic load;
		logic exec;
	} pir_cmd_t;

endpackage
`default_nettype wire

// File: rtl/pir_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pir_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output pir_pkg::pir_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign cmd.load = start & ~busy_q;
	assign cmd.exec = (state_q == S_EXEC);
	assign busy     = busy_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/pir_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pir_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pir_pkg::pir_cmd_t    cmd,
	input  wire pir_pkg::pir_in_t     din,
	input  wire pir_pkg::pir_cfg_t    cfg,
	input  wire pir_pkg::pir_cfgwr_t  cfg_wr,
	output pir_pkg::pir_out_t         dout
);

	pir_pkg::pir_in_t  item_s1;
	pir_pkg::pir_out_t res_q;
	pir_pkg::pir_out_t res;

	logic [31:0]                     slots_q [pir_pkg::SLOT_COUNT];
	logic [pir_pkg::SLOT_COUNT-1:0]  occ_q;
	logic                            pf_waiting_q;
	logic [63:0]                     pf_cursor_q;

	logic [pir_pkg::SLOT_W-1:0] free_idx, occ_idx;
	logic                       free_hit, occ_hit;

	logic do_park, do_pop, pf_done, pf_active, valid_ext;
	logic [31:0] word;

	// lowest free / lowest occupied slot
	always_comb begin
		free_idx = '0;
		occ_idx  = '0;
		for (int i = pir_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!occ_q[i]) free_idx = pir_pkg::SLOT_W'(i);
			if (occ_q[i])  occ_idx  = pir_pkg::SLOT_W'(i);
		end
		free_hit = ~&occ_q;
		occ_hit  = |occ_q;
	end

	assign word      = item_s1.intr_info;
	assign valid_ext = word[31] && (word[10:8] == pir_pkg::INTR_TYPE_EXT);
	assign pf_done   = pf_waiting_q && (pf_cursor_q > cfg.pf_range_to);
	assign pf_active = pf_waiting_q && !pf_done;

	always_comb begin
		res     = '0;
		do_park = 1'b0;
		do_pop  = 1'b0;
		if (item_s1.req_type == pir_pkg::REQ_EXT_INTR) begin
			if (cfg.hold_mode) begin
				do_park = 1'b1;
			end else if (valid_ext) begin
				if (item_s1.guest_if && !item_s1.block_mov_ss) begin
					res.inject_valid = 1'b1;
					res.inject_kind  = pir_pkg::KIND_WORD;
					res.inject_word  = word;
				end else begin
					do_park        = 1'b1;
					res.window_ctl = pir_pkg::WIN_ENABLE;
				end
			end else begin
				res.status = pir_pkg::ST_BADTYPE;
			end
			if (do_park) res.status = free_hit ? pir_pkg::ST_QUEUED : pir_pkg::ST_DROPPED;
		end else begin
			if (pf_active) begin
				res.inject_valid  = 1'b1;
				res.inject_kind   = pir_pkg::KIND_PF;
				res.fault_address = pf_cursor_q;
				res.fault_code    = cfg.pf_error_code;
			end else if (occ_hit) begin
				do_pop           = 1'b1;
				res.inject_valid = 1'b1;
				res.inject_kind  = pir_pkg::KIND_WORD;
				res.inject_word  = slots_q[occ_idx];
			end else begin
				res.window_ctl = pir_pkg::WIN_DISABLE;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) item_s1 <= din;
		if (cmd.exec) res_q <= res;
		if (cmd.exec && do_park && free_hit) slots_q[free_idx] <= word;
	end

	// control state: slot occupancy, page-fault walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			pf_waiting_q <= 1'b0;
			pf_cursor_q  <= '0;
		end else begin
			if (cmd.exec) begin
				if (do_park && free_hit) occ_q[free_idx] <= (word != 32'd0);
				if (do_pop) occ_q[occ_idx] <= 1'b0;
				if (item_s1.req_type == pir_pkg::REQ_WINDOW) begin
					if (pf_done) pf_waiting_q <= 1'b0;
					if (pf_active)
						pf_cursor_q <= pf_cursor_q + (item_s1.large_page ?
							pir_pkg::STEP_LARGE : pir_pkg::STEP_SMALL);
				end
			end
			if (cfg_wr.load_waiting) pf_waiting_q <= cfg_wr.waiting_val;
			if (cfg_wr.load_cursor)  pf_cursor_q  <= cfg_wr.cursor_val;
		end
	end

	assign dout = res_q;

endmodule
`default_nettype wire

// File: rtl/pending_interrupt_reinjector.sv
`timescale 1ns / 1ps
`default_nettype none
// Pending interrupt re-injector.
//
// Item channel: drive din and pulse start; the item is taken at a rising edge
// with start high and busy low. busy stays high for the one cycle the
// datapath works on it. Results come out on dout with done high for exactly
// one cycle, after the execute state; start may be held high so a
// new item is taken on that same done cycle; no item is taken while busy.
// The slot search (lowest free / lowest occupied of the slot buffer) and
// the slot write-back share the execute cycle.
// The receiver cannot stall: a result is valid only in its done cycle.
//
// Config: APB, 64-bit data, register i at byte address 8*i, pready tied
// high, no wait states. Write only while idle. Writing pf_arm reloads the
// page-fault waiting flag; writing pf_range_from loads the cursor and reloads
// the waiting flag from pf_arm.
//
// Reset (arst_n low) clears all config registers, the slot occupancy bits
// (every slot reads free), the cursor and the waiting flag. No clearing pass.
module pending_interrupt_reinjector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item channel
	input  wire logic                           start,
	output logic                                busy,
	input  wire pir_pkg::pir_in_t               din,
	output logic                                done,
	output pir_pkg::pir_out_t                   dout,
	// APB config port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pir_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [pir_pkg::DATA_W-1:0]     pwdata,
	output logic [pir_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	pir_pkg::pir_cmd_t   cmd;
	pir_pkg::pir_cfg_t   cfg_q;
	pir_pkg::pir_cfgwr_t cfg_wr;

	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[5:3];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				pir_pkg::REG_HOLD_MODE:  cfg_q.hold_mode     <= pwdata[0];
				pir_pkg::REG_PF_ARM:     cfg_q.pf_arm        <= pwdata[0];
				pir_pkg::REG_PF_FROM:    cfg_q.pf_range_from <= pwdata;
				pir_pkg::REG_PF_TO:      cfg_q.pf_range_to   <= pwdata;
				pir_pkg::REG_PF_ERRCODE: cfg_q.pf_error_code <= pwdata[31:0];
				default: ;  // unmapped: ignored
			endcase
		end
	end

	// side effects on the page-fault walk
	always_comb begin
		cfg_wr              = '0;
		cfg_wr.cursor_val   = pwdata;
		if (wr_en && reg_idx == pir_pkg::REG_PF_ARM) begin
			cfg_wr.load_waiting = 1'b1;
			cfg_wr.waiting_val  = pwdata[0];
		end
		if (wr_en && reg_idx == pir_pkg::REG_PF_FROM) begin
			cfg_wr.load_waiting = 1'b1;
			cfg_wr.waiting_val  = cfg_q.pf_arm;
			cfg_wr.load_cursor  = 1'b1;
		end
	end

	// readback
	always_comb begin
		unique case (reg_idx)
			pir_pkg::REG_HOLD_MODE:  prdata = {63'd0, cfg_q.hold_mode};
			pir_pkg::REG_PF_ARM:     prdata = {63'd0, cfg_q.pf_arm};
			pir_pkg::REG_PF_FROM:    prdata = cfg_q.pf_range_from;
			pir_pkg::REG_PF_TO:      prdata = cfg_q.pf_range_to;
			pir_pkg::REG_PF_ERRCODE: prdata = {32'd0, cfg_q.pf_error_code};
			default:                 prdata = '0;
		endcase
	end

	pir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pir_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.din    (din),
		.cfg    (cfg_q),
		.cfg_wr (cfg_wr),
		.dout   (dout)
	);

	// an accepted item always occupies the execute cycle next
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not enter execute");

	// execute lasts one cycle and ends in exactly one done
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("execute did not complete in one cycle");

	// no done without a preceding execute cycle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("spurious done");

	// page-fault results are always injections
	a_pf_inject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dout.inject_kind == pir_pkg::KIND_PF) |-> dout.inject_valid)
		else $error("page fault result without inject");

endmodule
`default_nettype wire
